// ===== rtl/mscc_pkg.sv =====
package mscc_pkg;

    localparam int CB     = 16;
    localparam int FB     = CB - 2;
    localparam int STEPS  = 10;
    localparam int SIZE_W = 15;
    localparam int QW     = 2 * CB;
    localparam int PW     = 4 * CB;
    localparam int CW     = 4 * CB + 2;

    typedef logic signed [CB-1:0] t_coord;

    typedef struct packed {
        t_coord cell_x;
        t_coord cell_y;
        logic [SIZE_W-1:0] cell_size;
    } t_cell;

    typedef struct packed {
        t_coord seg_start_x;
        t_coord seg_start_y;
        t_coord seg_end_x;
        t_coord seg_end_y;
        logic   last_segment;
    } t_res;

    // inside end and outside end of one edge
    typedef struct packed {
        t_coord ix;
        t_coord iy;
        t_coord px;
        t_coord py;
    } t_edge;

    typedef struct packed {
        t_edge s;
        t_edge e;
        logic  last;
    } t_seg;

    typedef struct packed {
        t_coord [3:0] cx;
        t_coord [3:0] cy;
        logic   [3:0] ins;
    } t_corners;

    typedef struct packed {
        logic [1:0] cnt;
        logic [1:0] a0;
        logic [1:0] b0;
        logic [1:0] a1;
        logic [1:0] b1;
    } t_pairs;

    function automatic t_pairs pair_lookup(input logic [3:0] pat);
        t_pairs p;
        p = '0;
        unique case (pat)
            4'd1, 4'd14: begin p.cnt = 2'd1; p.a0 = 2'd2; p.b0 = 2'd3; end
            4'd2, 4'd13: begin p.cnt = 2'd1; p.a0 = 2'd1; p.b0 = 2'd2; end
            4'd3, 4'd12: begin p.cnt = 2'd1; p.a0 = 2'd1; p.b0 = 2'd3; end
            4'd4, 4'd11: begin p.cnt = 2'd1; p.a0 = 2'd0; p.b0 = 2'd1; end
            4'd6, 4'd9:  begin p.cnt = 2'd1; p.a0 = 2'd0; p.b0 = 2'd2; end
            4'd7, 4'd8:  begin p.cnt = 2'd1; p.a0 = 2'd0; p.b0 = 2'd3; end
            4'd5: begin
                p.cnt = 2'd2; p.a0 = 2'd0; p.b0 = 2'd3; p.a1 = 2'd1; p.b1 = 2'd2;
            end
            4'd10: begin
                p.cnt = 2'd2; p.a0 = 2'd0; p.b0 = 2'd1; p.a1 = 2'd2; p.b1 = 2'd3;
            end
            default: p = '0;
        endcase
        return p;
    endfunction

    // floor((a+b)/2)
    function automatic t_coord half_floor(input t_coord a, input t_coord b);
        logic signed [CB:0] d;
        d = {a[CB-1], a} + {b[CB-1], b};
        return d[CB:1];
    endfunction

endpackage

// ===== rtl/mscc_cell_if.sv =====
interface mscc_cell_if import mscc_pkg::*; ();
    logic  valid;
    logic  ready;
    t_cell data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/mscc_seg_if.sv =====
interface mscc_seg_if import mscc_pkg::*; ();
    logic valid;
    logic ready;
    t_res data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/mscc_cfg_if.sv =====
interface mscc_cfg_if import mscc_pkg::*; ();
    logic   valid;
    logic   ready;
    t_coord data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/marching_squares_cell_contour.sv =====
// Pipeline from cell beat to segment beat: corner test, issue register,
// 10 bisection steps, output register.
// Throughput: one segment per cycle while o_seg.ready does not stall; a
// two-segment cell holds the single segment issue stage and blocks new cells.
// Reset: synchronous, active low; clears valid bits, slice height to 0.
module marching_squares_cell_contour import mscc_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    mscc_cell_if.sink  i_cell,
    mscc_cfg_if.sink   i_cfg,
    mscc_seg_if.source o_seg
);

    t_coord   r_slice;
    logic     en, hold;
    logic     cor_valid;
    t_corners cor;
    logic     r_iss_valid, r_iss_k;
    t_corners r_iss;
    t_pairs   pr;
    logic [1:0] ea, eb, e0, e1;
    t_seg     iss_seg;
    logic     iss_valid;
    logic     sv [STEPS+1];
    t_seg     sg [STEPS+1];
    logic     r_out_valid;
    t_res     r_out;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slice <= '0;
        end else if (i_cfg.valid) begin
            r_slice <= i_cfg.data;
        end
    end

    assign en   = !r_out_valid || o_seg.ready;
    assign pr   = pair_lookup({r_iss.ins[0], r_iss.ins[1], r_iss.ins[2], r_iss.ins[3]});
    assign hold = r_iss_valid && (pr.cnt == 2'd2) && !r_iss_k;
    assign i_cell.ready = en && !hold;

    mscc_corner u_corner (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en && !hold),
        .i_valid(i_cell.valid),
        .i_cell (i_cell.data),
        .i_z    (r_slice),
        .o_valid(cor_valid),
        .o_cor  (cor)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iss_valid <= 1'b0;
            r_iss_k     <= 1'b0;
        end else if (en) begin
            if (hold) begin
                r_iss_k <= 1'b1;
            end else begin
                r_iss_valid <= cor_valid;
                r_iss_k     <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && !hold) begin
            r_iss <= cor;
        end
    end

    assign ea = r_iss_k ? pr.a1 : pr.a0;
    assign eb = r_iss_k ? pr.b1 : pr.b0;

    // orient each edge so its first end is the inside corner
    always_comb begin
        e0 = ea + 2'd1;
        e1 = eb + 2'd1;
        iss_seg.s.ix = r_iss.ins[ea] ? r_iss.cx[ea] : r_iss.cx[e0];
        iss_seg.s.iy = r_iss.ins[ea] ? r_iss.cy[ea] : r_iss.cy[e0];
        iss_seg.s.px = r_iss.ins[ea] ? r_iss.cx[e0] : r_iss.cx[ea];
        iss_seg.s.py = r_iss.ins[ea] ? r_iss.cy[e0] : r_iss.cy[ea];
        iss_seg.e.ix = r_iss.ins[eb] ? r_iss.cx[eb] : r_iss.cx[e1];
        iss_seg.e.iy = r_iss.ins[eb] ? r_iss.cy[eb] : r_iss.cy[e1];
        iss_seg.e.px = r_iss.ins[eb] ? r_iss.cx[e1] : r_iss.cx[eb];
        iss_seg.e.py = r_iss.ins[eb] ? r_iss.cy[e1] : r_iss.cy[eb];
        iss_seg.last = (pr.cnt == 2'd1) || r_iss_k;
        iss_valid    = r_iss_valid && (pr.cnt != 2'd0);
    end

    assign sv[0] = iss_valid;
    assign sg[0] = iss_seg;

    for (genvar g = 0; g < STEPS; g++) begin : g_step
        mscc_bstep u_step (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_valid(sv[g]),
            .i_seg  (sg[g]),
            .i_z    (r_slice),
            .o_valid(sv[g+1]),
            .o_seg  (sg[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= sv[STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.seg_start_x  <= half_floor(sg[STEPS].s.ix, sg[STEPS].s.px);
            r_out.seg_start_y  <= half_floor(sg[STEPS].s.iy, sg[STEPS].s.py);
            r_out.seg_end_x    <= half_floor(sg[STEPS].e.ix, sg[STEPS].e.px);
            r_out.seg_end_y    <= half_floor(sg[STEPS].e.iy, sg[STEPS].e.py);
            r_out.last_segment <= sg[STEPS].last;
        end
    end

    assign o_seg.valid = r_out_valid;
    assign o_seg.data  = r_out;

    a_second_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && hold |=> r_iss_k && r_iss_valid)
        else $error("second segment of cell not issued");

    a_second_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_iss_valid && r_iss_k |-> iss_valid && iss_seg.last)
        else $error("second segment not marked last");

    a_no_take_on_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hold |-> !i_cell.ready)
        else $error("cell taken while issue stage busy");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_out_valid && !r_iss_valid)
        else $error("valid set after reset");

endmodule

// ===== rtl/mscc_inside.sv =====
module mscc_inside import mscc_pkg::*; (
    input  logic   i_clk,
    input  logic   i_en,
    input  t_coord i_x,
    input  t_coord i_y,
    input  t_coord i_z,
    output logic   o_inside
);

    localparam logic [CW-1:0] K_OFS = CW'(3) << (4 * FB - 3);

    logic [CB-1:0] mx, my, mz;
    logic [QW-1:0] r_qx, r_qy, r_qz;
    logic [PW-1:0] r_px, r_py, r_pz;
    logic [QW+1:0] r_qs;
    logic [CW-1:0] lhs, rhs;
    logic          r_in;

    assign mx = i_x[CB-1] ? CB'(-i_x) : CB'(i_x);
    assign my = i_y[CB-1] ? CB'(-i_y) : CB'(i_y);
    assign mz = i_z[CB-1] ? CB'(-i_z) : CB'(i_z);

    // f < 0 scaled by 2^(4F)/8: sum q^2 + 3*2^(4F-3) < 2^(2F) * sum q
    assign lhs = CW'(r_px) + CW'(r_py) + CW'(r_pz) + K_OFS;
    assign rhs = CW'(r_qs) << (2 * FB);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_qx <= QW'(mx) * QW'(mx);
            r_qy <= QW'(my) * QW'(my);
            r_qz <= QW'(mz) * QW'(mz);
            r_px <= PW'(r_qx) * PW'(r_qx);
            r_py <= PW'(r_qy) * PW'(r_qy);
            r_pz <= PW'(r_qz) * PW'(r_qz);
            r_qs <= (QW+2)'(r_qx) + (QW+2)'(r_qy) + (QW+2)'(r_qz);
            r_in <= lhs < rhs;
        end
    end

    assign o_inside = r_in;

endmodule

// ===== rtl/mscc_corner.sv =====
module mscc_corner import mscc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  logic     i_valid,
    input  t_cell    i_cell,
    input  t_coord   i_z,
    output logic     o_valid,
    output t_corners o_cor
);

    localparam logic signed [CB:0] TOP = (CB+1)'((1 << (CB - 1)) - 1);

    logic signed [CB:0] xs, ys;
    t_coord             x1, y1;
    t_coord [3:0]       cx, cy;
    t_coord [3:0]       r_cx [3];
    t_coord [3:0]       r_cy [3];
    logic   [2:0]       r_v;
    logic   [3:0]       ins;

    assign xs = {i_cell.cell_x[CB-1], i_cell.cell_x} + (CB+1)'(i_cell.cell_size);
    assign ys = {i_cell.cell_y[CB-1], i_cell.cell_y} + (CB+1)'(i_cell.cell_size);
    assign x1 = (xs > TOP) ? TOP[CB-1:0] : xs[CB-1:0];
    assign y1 = (ys > TOP) ? TOP[CB-1:0] : ys[CB-1:0];

    assign cx = {i_cell.cell_x, x1, x1, i_cell.cell_x};
    assign cy = {y1, y1, i_cell.cell_y, i_cell.cell_y};

    for (genvar g = 0; g < 4; g++) begin : g_cor
        mscc_inside u_in (
            .i_clk   (i_clk),
            .i_en    (i_en),
            .i_x     (cx[g]),
            .i_y     (cy[g]),
            .i_z     (i_z),
            .o_inside(ins[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cx[0] <= cx;
            r_cy[0] <= cy;
            r_cx[1] <= r_cx[0];
            r_cy[1] <= r_cy[0];
            r_cx[2] <= r_cx[1];
            r_cy[2] <= r_cy[1];
        end
    end

    assign o_valid   = r_v[2];
    assign o_cor.cx  = r_cx[2];
    assign o_cor.cy  = r_cy[2];
    assign o_cor.ins = ins;

endmodule

// ===== rtl/mscc_bstep.sv =====
module mscc_bstep import mscc_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  logic   i_valid,
    input  t_seg   i_seg,
    input  t_coord i_z,
    output logic   o_valid,
    output t_seg   o_seg
);

    t_coord [3:0] mid;
    t_coord [3:0] r_mid [3];
    t_seg         r_seg [3];
    logic   [2:0] r_v;
    logic         ins_s, ins_e;

    assign mid[0] = half_floor(i_seg.s.ix, i_seg.s.px);
    assign mid[1] = half_floor(i_seg.s.iy, i_seg.s.py);
    assign mid[2] = half_floor(i_seg.e.ix, i_seg.e.px);
    assign mid[3] = half_floor(i_seg.e.iy, i_seg.e.py);

    mscc_inside u_in_s (
        .i_clk(i_clk), .i_en(i_en), .i_x(mid[0]), .i_y(mid[1]), .i_z(i_z),
        .o_inside(ins_s)
    );

    mscc_inside u_in_e (
        .i_clk(i_clk), .i_en(i_en), .i_x(mid[2]), .i_y(mid[3]), .i_z(i_z),
        .o_inside(ins_e)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_seg[0] <= i_seg;
            r_mid[0] <= mid;
            r_seg[1] <= r_seg[0];
            r_mid[1] <= r_mid[0];
            r_seg[2] <= r_seg[1];
            r_mid[2] <= r_mid[1];
        end
    end

    // midpoint replaces the inside end or the outside end
    always_comb begin
        o_seg = r_seg[2];
        if (ins_s) begin
            o_seg.s.ix = r_mid[2][0];
            o_seg.s.iy = r_mid[2][1];
        end else begin
            o_seg.s.px = r_mid[2][0];
            o_seg.s.py = r_mid[2][1];
        end
        if (ins_e) begin
            o_seg.e.ix = r_mid[2][2];
            o_seg.e.iy = r_mid[2][3];
        end else begin
            o_seg.e.px = r_mid[2][2];
            o_seg.e.py = r_mid[2][3];
        end
    end

    assign o_valid = r_v[2];

endmodule
